// ----- src/tlb_fifo_lru_entry_table_unit_macros.svh -----
// Assertion macros shared by the translation buffer RTL.
// Assumes the including module has clk_i and rst_ni (active low) in scope.
`ifndef TLB_FIFO_LRU_ENTRY_TABLE_UNIT_MACROS_SVH
`define TLB_FIFO_LRU_ENTRY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TLBFL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("translation buffer assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define TLBFL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("translation buffer assertion failed");

`endif

// ----- src/tlbfl_pkg.sv -----
// Shared types and constants of the translation buffer.
// No dependencies; used by tlbfl_cell and tlb_fifo_lru_entry_table_unit.
`default_nettype none

package tlbfl_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int TAG_W    = 16;
  localparam int FRAME_W  = 16;
  localparam int ACTION_W = 2;
  localparam int EIU_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Reset values of the configuration registers.
  localparam logic [EIU_W-1:0] EIU_RESET = EIU_W'(16);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_INVAL  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRIES_IN_USE = 1'b0,
    CFG_REPLACE_LRU    = 1'b1
  } cfg_idx_e;

  // Replacement order selected by the replace_lru register.
  localparam logic REPL_FIFO = 1'b0;
  localparam logic REPL_LRU  = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]   process;
    logic [TAG_W-1:0]   page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic load_new;  // take the incoming request's translation
    logic shift;     // take the neighbor's (one slot newer) translation
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/tlbfl_cell.sv -----
// One slot of the age-ordered translation chain: holds an entry, compares its tags.
// Depends on tlbfl_pkg.
`default_nettype none

module tlbfl_cell
  import tlbfl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire entry_t     req_i,
  input  wire entry_t     newer_i,
  input  wire cell_ctrl_t ctrl_i,
  output entry_t          entry_o,
  output logic            match_o
);

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load_new) begin
      entry_d = req_i;
    end else if (ctrl_i.shift) begin
      entry_d = newer_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign match_o = (entry_q.process == req_i.process) && (entry_q.page == req_i.page);
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- src/tlb_fifo_lru_entry_table_unit.sv -----
// Fully associative translation buffer built as a chain of slot cells in age order.
// Depends on tlbfl_pkg, tlbfl_cell and tlb_fifo_lru_entry_table_unit_macros.svh.
`default_nettype none

// A request is taken at a rising edge where start_i is high and busy_o is low. In the
// following cycle busy_o is high while every slot compares its tags in parallel; at the
// end of that cycle the table is updated (a removal shifts all newer slots down by one
// step) and the result is registered. The result is on the result ports in the cycle
// after that, with done_o high for exactly one cycle; there is no way to hold it off.
// Since busy_o is low again during the result cycle, the next request can be taken at
// the edge that ends it; no new request is taken while one is executing. Slot 0 is the
// oldest entry. Configuration writes take effect at once and must be made while no
// request is in flight.

`include "tlb_fifo_lru_entry_table_unit_macros.svh"

module tlb_fifo_lru_entry_table_unit
  import tlbfl_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [ACTION_W-1:0]   action_i,
  input  wire logic [TAG_W-1:0]      process_id_i,
  input  wire logic [TAG_W-1:0]      page_number_i,
  input  wire logic [FRAME_W-1:0]    frame_number_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic [FRAME_W-1:0]         found_frame_o,
  output logic                       accepted_o
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Configuration registers.
  logic [EIU_W-1:0] eiu_q;
  logic             repl_q;

  // Registered request.
  logic                req_valid_q;
  logic [ACTION_W-1:0] action_q;
  entry_t              req_q;

  logic [CNT_W-1:0] occ_q;
  logic [CNT_W-1:0] occ_d;

  logic               done_q;
  logic               hit_q;
  logic               hit_d;
  logic [FRAME_W-1:0] frame_q;
  logic [FRAME_W-1:0] frame_d;
  logic               acc_q;
  logic               acc_d;

  entry_t                 cell_entry [MAX_ENTRIES];
  entry_t                 cell_newer [MAX_ENTRIES];
  cell_ctrl_t             cell_ctrl  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] raw_match;
  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_ENTRIES-1:0] newer_valid;
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] first;
  logic [MAX_ENTRIES-1:0] ge_mask;
  logic [MAX_ENTRIES-1:0] rm_mask;

  logic [CNT_W-1:0]   cap;
  logic               active;
  logic               any_hit;
  logic [FRAME_W-1:0] hit_frame;
  logic               rm;
  logic               rm_first;
  logic               app;
  logic [CNT_W-1:0]   wr_pos;

  // ---------------------------------------------------------------- cell chain
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign cell_newer[g] = '0;
    end else begin : g_mid
      assign cell_newer[g] = cell_entry[g+1];
    end

    assign valid[g]       = 32'(g) < 32'(occ_q);
    assign newer_valid[g] = 32'(g + 1) < 32'(occ_q);

    tlbfl_cell u_cell (
      .clk_i   (clk_i),
      .req_i   (req_q),
      .newer_i (cell_newer[g]),
      .ctrl_i  (cell_ctrl[g]),
      .entry_o (cell_entry[g]),
      .match_o (raw_match[g])
    );

    assign cell_ctrl[g].load_new = app && (32'(wr_pos) == 32'(g));
    assign cell_ctrl[g].shift    = rm && rm_mask[g] && newer_valid[g];
  end

  // ---------------------------------------------------------------- match
  assign match   = raw_match & valid;
  // Lowest set bit is the oldest matching slot.
  assign first   = match & (~match + MAX_ENTRIES'(1));
  assign ge_mask = ~(first - MAX_ENTRIES'(1));
  assign any_hit = |match;

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_frame = hit_frame | (cell_entry[i].frame & {FRAME_W{first[i]}});
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    if (32'(eiu_q) > MAX_ENTRIES) begin
      cap = CNT_W'(MAX_ENTRIES);
    end else begin
      cap = CNT_W'(eiu_q);
    end
  end

  always_comb begin
    active   = 1'b0;
    rm       = 1'b0;
    rm_first = 1'b0;
    app      = 1'b0;
    if (req_valid_q && (cap != '0)) begin
      case (action_q)
        ACT_LOOKUP: begin
          active = 1'b1;
        end
        ACT_LOAD: begin
          active = 1'b1;
          if (any_hit) begin
            if (repl_q == REPL_LRU) begin
              rm       = 1'b1;
              rm_first = 1'b1;
              app      = 1'b1;
            end
          end else begin
            app = 1'b1;
            // Full, or capacity lowered below occupancy: the oldest entry goes.
            if (occ_q >= cap) begin
              rm = 1'b1;
            end
          end
        end
        ACT_INVAL: begin
          active = 1'b1;
          if (any_hit) begin
            rm       = 1'b1;
            rm_first = 1'b1;
          end
        end
        default: begin
          active = 1'b0;
        end
      endcase
    end
  end

  assign rm_mask = rm_first ? ge_mask : '1;
  assign wr_pos  = occ_q - CNT_W'(rm);
  assign occ_d   = occ_q - CNT_W'(rm) + CNT_W'(app);

  assign hit_d   = active && any_hit;
  assign frame_d = (active && any_hit) ? hit_frame : '0;
  assign acc_d   = app;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eiu_q  <= EIU_RESET;
      repl_q <= REPL_FIFO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENTRIES_IN_USE: eiu_q  <= cfg_wdata_i;
        CFG_REPLACE_LRU:    repl_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
      occ_q       <= '0;
    end else begin
      req_valid_q <= start_i && !req_valid_q;
      done_q      <= req_valid_q;
      occ_q       <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !req_valid_q) begin
      action_q      <= action_i;
      req_q.process <= process_id_i;
      req_q.page    <= page_number_i;
      req_q.frame   <= frame_number_i;
    end
    if (req_valid_q) begin
      hit_q   <= hit_d;
      frame_q <= frame_d;
      acc_q   <= acc_d;
    end
  end

  assign busy_o        = req_valid_q;
  assign done_o        = done_q;
  assign hit_o         = done_q && hit_q;
  assign found_frame_o = done_q ? frame_q : '0;
  assign accepted_o    = done_q && acc_q;

  // ---------------------------------------------------------------- checks
  `TLBFL_ASSERT_IMP(a_done_not_busy, done_q, !req_valid_q)
  `TLBFL_ASSERT_NXT(a_occ_only_on_exec, !req_valid_q, occ_q == $past(occ_q))
  `TLBFL_ASSERT_IMP(a_occ_bounded, 1'b1, 32'(occ_q) <= MAX_ENTRIES)
  `TLBFL_ASSERT_IMP(a_miss_frame_zero, done_q && !hit_q, frame_q == '0)
  `TLBFL_ASSERT_IMP(a_shift_needs_remove, |first && !any_hit, 1'b0)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for tlb_fifo_lru_entry_table_unit: directed and random requests,
// each checked against a behavioral model of the age-ordered translation table.
// Depends on tlbfl_pkg and the unit itself.
module testbench;
  import tlbfl_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int MAX_GAP = 19;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               accepted;
  } xlat_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  start_i = 1'b0;
  logic [ACTION_W-1:0]   action_i = '0;
  logic [TAG_W-1:0]      process_id_i = '0;
  logic [TAG_W-1:0]      page_number_i = '0;
  logic [FRAME_W-1:0]    frame_number_i = '0;
  logic                  busy_o;
  logic                  done_o;
  logic                  hit_o;
  logic [FRAME_W-1:0]    found_frame_o;
  logic                  accepted_o;

  // Model of the table: slot 0 is the oldest translation.
  logic [TAG_W-1:0]   tbl_process [TABLE_DEPTH];
  logic [TAG_W-1:0]   tbl_page    [TABLE_DEPTH];
  logic [FRAME_W-1:0] tbl_frame   [TABLE_DEPTH];
  int unsigned        tbl_count = 0;
  logic [EIU_W-1:0]   slots_enabled = EIU_RESET;
  logic               lru_mode = REPL_FIFO;

  xlat_result_t pending_results[$];
  int unsigned  fail_count = 0;
  bit           burst_mode = 1'b0;

  tlb_fifo_lru_entry_table_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .process_id_i   (process_id_i),
    .page_number_i  (page_number_i),
    .frame_number_i (frame_number_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .found_frame_o  (found_frame_o),
    .accepted_o     (accepted_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void drop_slot(int unsigned idx);
    for (int unsigned i = idx; i + 1 < tbl_count; i++) begin
      tbl_process[i] = tbl_process[i+1];
      tbl_page[i]    = tbl_page[i+1];
      tbl_frame[i]   = tbl_frame[i+1];
    end
    tbl_count--;
  endfunction

  function automatic void push_slot(logic [TAG_W-1:0] pid, logic [TAG_W-1:0] pg,
                                    logic [FRAME_W-1:0] fr);
    if (tbl_count < TABLE_DEPTH) begin
      tbl_process[tbl_count] = pid;
      tbl_page[tbl_count]    = pg;
      tbl_frame[tbl_count]   = fr;
      tbl_count++;
    end
  endfunction

  // Applies one request to the model table and returns the translation it reports.
  function automatic xlat_result_t predict_translation(logic [ACTION_W-1:0] act,
                                                       logic [TAG_W-1:0] pid,
                                                       logic [TAG_W-1:0] pg,
                                                       logic [FRAME_W-1:0] fr);
    xlat_result_t res;
    int unsigned  cap;
    int unsigned  slot;
    res = '0;
    cap = (slots_enabled > TABLE_DEPTH) ? TABLE_DEPTH : slots_enabled;
    if (cap == 0 || act == ACT_RESERVED) return res;
    // The oldest matching slot wins.
    slot = TABLE_DEPTH;
    for (int unsigned i = 0; i < tbl_count; i++) begin
      if (slot == TABLE_DEPTH && tbl_process[i] == pid && tbl_page[i] == pg) slot = i;
    end
    if (slot < TABLE_DEPTH) begin
      res.hit   = 1'b1;
      res.frame = tbl_frame[slot];
    end
    if (act == ACT_LOAD) begin
      if (!res.hit) begin
        // A table at or above its capacity drops the oldest entry first.
        if (tbl_count >= cap) drop_slot(0);
        push_slot(pid, pg, fr);
        res.accepted = 1'b1;
      end else if (lru_mode == REPL_LRU) begin
        drop_slot(slot);
        push_slot(pid, pg, fr);
        res.accepted = 1'b1;
      end
    end else if (act == ACT_INVAL && res.hit) begin
      drop_slot(slot);
    end
    return res;
  endfunction

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [TAG_W-1:0] pid,
                              input logic [TAG_W-1:0] pg, input logic [FRAME_W-1:0] fr);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    action_i       <= act;
    process_id_i   <= pid;
    page_number_i  <= pg;
    frame_number_i <= fr;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_translation(act, pid, pg, fr));
  endtask

  task automatic wait_results_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes both registers while the unit is idle.
  task automatic configure_table(input logic [CFG_DATA_W-1:0] cap, input logic lru);
    wait_results_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ENTRIES_IN_USE;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_REPLACE_LRU;
    // Upper bits are noise; only bit 0 selects the replacement order.
    cfg_wdata_i <= {4'($urandom), lru};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slots_enabled = cap;
    lru_mode      = lru;
  endtask

  task automatic test_empty_and_extremes();
    send_request(ACT_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF);
    send_request(ACT_INVAL, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_request(ACT_LOAD, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_request(ACT_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000);
    // A load of a present translation is ignored in first-in first-out order.
    send_request(ACT_LOAD, 16'h0000, 16'h0000, 16'h1234);
    send_request(ACT_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ACT_INVAL, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_LOAD, 16'h0005, 16'h0006, 16'hABCD);
  endtask

  task automatic test_lru_refresh();
    configure_table(5'd16, REPL_LRU);
    send_request(ACT_LOAD, 16'hFFFF, 16'hFFFF, 16'h5555);
    send_request(ACT_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_shrunken_capacity();
    configure_table(5'd4, REPL_FIFO);
    send_request(ACT_LOAD, 16'h0100, 16'h0200, 16'h0300);
    send_request(ACT_LOAD, 16'h0101, 16'h0201, 16'h0301);
    // Four entries are held; with capacity two, a new load still only drops the oldest.
    configure_table(5'd2, REPL_FIFO);
    send_request(ACT_LOAD, 16'h0102, 16'h0202, 16'h0302);
    send_request(ACT_LOOKUP, 16'h0005, 16'h0006, 16'h0000);
  endtask

  task automatic test_disabled_table();
    configure_table(5'd0, REPL_LRU);
    send_request(ACT_LOOKUP, 16'h0100, 16'h0200, 16'h0000);
    send_request(ACT_LOAD, 16'h0777, 16'h0888, 16'h0999);
    send_request(ACT_INVAL, 16'h0100, 16'h0200, 16'h0000);
    // Values above the table depth act as the full depth.
    configure_table(5'd31, REPL_LRU);
    send_request(ACT_LOOKUP, 16'h0100, 16'h0200, 16'h0000);
  endtask

  task automatic run_random_phase(input logic [CFG_DATA_W-1:0] cap, input logic lru);
    logic [TAG_W-1:0]    pid_pool [4];
    logic [TAG_W-1:0]    page_pool [6];
    logic [ACTION_W-1:0] act;
    logic [TAG_W-1:0]    pid;
    logic [TAG_W-1:0]    pg;
    int unsigned         roll;
    configure_table(cap, lru);
    foreach (pid_pool[i]) pid_pool[i] = TAG_W'($urandom);
    foreach (page_pool[i]) page_pool[i] = TAG_W'($urandom);
    for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
      if ($urandom_range(0, 29) == 0) burst_mode = !burst_mode;
      roll = $urandom_range(0, 99);
      if (roll < 35) act = ACT_LOOKUP;
      else if (roll < 75) act = ACT_LOAD;
      else if (roll < 95) act = ACT_INVAL;
      else act = ACT_RESERVED;
      // Small tag pools make hits and evictions common; a few tags are fully random.
      pid = ($urandom_range(0, 9) == 0) ? TAG_W'($urandom) : pid_pool[$urandom_range(0, 3)];
      pg  = ($urandom_range(0, 9) == 0) ? TAG_W'($urandom) : page_pool[$urandom_range(0, 5)];
      send_request(act, pid, pg, FRAME_W'($urandom));
      if (k == ITEMS_PER_PHASE / 2) wait_results_drained();
    end
  endtask

  task automatic test_random_mix();
    run_random_phase(5'd16, REPL_FIFO);
    run_random_phase(5'd16, REPL_LRU);
    run_random_phase(5'd3, REPL_LRU);
    run_random_phase(5'd1, REPL_FIFO);
    run_random_phase(5'd0, REPL_LRU);
    run_random_phase(5'd31, REPL_FIFO);
    run_random_phase(5'd8, REPL_LRU);
    run_random_phase(5'd5, REPL_FIFO);
    run_random_phase(5'd2, REPL_LRU);
    run_random_phase(5'd17, REPL_LRU);
    run_random_phase(CFG_DATA_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    run_random_phase(CFG_DATA_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk_i) begin : check_results
    xlat_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (hit_o !== exp_res.hit) begin
          $error("hit: expected %0d, got %0d", exp_res.hit, hit_o);
          fail_count++;
        end
        if (found_frame_o !== exp_res.frame) begin
          $error("found_frame: expected %h, got %h", exp_res.frame, found_frame_o);
          fail_count++;
        end
        if (accepted_o !== exp_res.accepted) begin
          $error("accepted: expected %0d, got %0d", exp_res.accepted, accepted_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_extremes();
    test_lru_refresh();
    test_shrunken_capacity();
    test_disabled_table();
    test_random_mix();
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tlb_fifo_lru_entry_table_unit verification clean");
    end else begin
      $display("tlb_fifo_lru_entry_table_unit verification failed");
    end
    $finish;
  end

  initial begin
    #(20 * TIMEOUT_CYCLES);
    $display("tlb_fifo_lru_entry_table_unit verification failed");
    $finish;
  end

endmodule
